>>> design/pnp_pkg.sv
// ============================================================================
// pnp_pkg
// Shared types, codes and helpers for the prefixed number parser.
// ============================================================================
`default_nettype none

package pnp_pkg;

  localparam int CHAR_W          = 8;
  localparam int VALUE_OUT_W     = 32;
  localparam int STATUS_W        = 2;
  localparam int DIGIT_W         = 6;
  localparam int VALUE_WIDTH_DEF = 32;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CHAR  = 2'd1,
    ST_BIG_DIGIT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_HEX = 2'd1,
    RADIX_OCT = 2'd2
  } radix_t;

  localparam logic [CHAR_W-1:0] CH_NUL  = 8'h00;
  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LA   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LZ   = 8'h7a;
  localparam logic [CHAR_W-1:0] CH_UA   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UZ   = 8'h5a;
  localparam logic [CHAR_W-1:0] CH_X    = 8'h78;
  localparam logic [CHAR_W-1:0] CH_O    = 8'h6f;

  localparam logic [DIGIT_W-1:0] LETTER_BASE = 6'd10;

  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] code;
  } item_t;

  typedef struct packed {
    logic                   valid;
    logic [VALUE_OUT_W-1:0] value;
    status_t                status;
  } result_t;

  typedef struct packed {
    logic               ok;
    logic [DIGIT_W-1:0] digit;
  } digit_t;

  function automatic digit_t char_digit(input logic [CHAR_W-1:0] c);
    digit_t d;
    d.ok    = 1'b1;
    d.digit = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d.digit = DIGIT_W'(c - CH_ZERO);
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d.digit = DIGIT_W'(c - CH_LA) + LETTER_BASE;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d.digit = DIGIT_W'(c - CH_UA) + LETTER_BASE;
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

  function automatic logic [DIGIT_W-1:0] radix_base(input radix_t r);
    logic [DIGIT_W-1:0] b;
    unique case (r)
      RADIX_HEX: b = 6'd16;
      RADIX_OCT: b = 6'd8;
      default:   b = 6'd10;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

>>> design/pnp_if.sv
// ============================================================================
// pnp_if
// Valid/ready channels for character beats and result beats.
// ============================================================================
`default_nettype none

interface pnp_char_if;
  logic                      valid;
  logic                      ready;
  logic [pnp_pkg::CHAR_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface pnp_result_if;
  logic                           valid;
  logic                           ready;
  logic [pnp_pkg::VALUE_OUT_W-1:0] value;
  logic [pnp_pkg::STATUS_W-1:0]    status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

>>> design/prefixed_number_parser_top.sv
// ============================================================================
// prefixed_number_parser_top
// Character-stream number parser with 0x / 0o radix prefixes.
// ============================================================================
// Throughput: one character beat per cycle; a terminator beat waits in the
//   input register until the result register is free, and the accumulated
//   value is then registered there. Digits use a combinational shift-add.
// Reset: synchronous active-low rst_n clears both stages and returns the parser
//   to decimal with an empty accumulator and no error held.
`default_nettype none

module prefixed_number_parser_top #(
  parameter int VALUE_WIDTH = pnp_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  pnp_char_if.sink      in_chan,
  pnp_result_if.source  out_chan
);
  import pnp_pkg::*;

  item_t   item;
  result_t res;
  logic    take;
  logic    out_free;

  pnp_char_stage u_char (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .in_code  (in_chan.char_code),
    .take     (take),
    .item     (item)
  );

  pnp_digit_core #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .item     (item),
    .out_free (out_free),
    .take     (take),
    .res      (res)
  );

  pnp_result_stage u_res (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .out_free   (out_free),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_value  (out_chan.value),
    .out_status (out_chan.status)
  );

endmodule

`default_nettype wire

>>> design/pnp_char_stage.sv
// ============================================================================
// pnp_char_stage
// Input register: holds one character beat until the core takes it.
// ============================================================================
`default_nettype none

module pnp_char_stage (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [pnp_pkg::CHAR_W-1:0]  in_code,
  input  wire logic                        take,
  output pnp_pkg::item_t                   item
);
  import pnp_pkg::*;

  logic              valid_r;
  logic              valid_nxt;
  logic [CHAR_W-1:0] code_r;

  assign in_ready   = !valid_r || take;
  assign valid_nxt  = in_valid || (valid_r && !take);
  assign item.valid = valid_r;
  assign item.code  = code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      code_r <= in_code;
    end
  end

endmodule

`default_nettype wire

>>> design/pnp_digit_core.sv
// ============================================================================
// pnp_digit_core
// Prefix detection, digit decode and multiply-add with held error status.
// ============================================================================
`default_nettype none

module pnp_digit_core #(
  parameter int VALUE_WIDTH = pnp_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire pnp_pkg::item_t  item,
  input  wire logic            out_free,
  output logic                 take,
  output pnp_pkg::result_t     res
);
  import pnp_pkg::*;

  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  radix_t                 radix_r, radix_nxt;
  logic [1:0]             pos_r, pos_nxt;
  logic                   lz_r, lz_nxt;
  status_t                err_r, err_nxt;

  logic                   is_term;
  digit_t                 dec;
  logic [DIGIT_W-1:0]     base;
  logic [VALUE_WIDTH-1:0] scaled;

  assign is_term = (item.code == CH_NUL);
  assign take    = item.valid && (!is_term || out_free);
  assign dec     = char_digit(item.code);
  assign base    = radix_base(radix_r);

  always_comb begin
    unique case (radix_r)
      RADIX_HEX: scaled = acc_r << 4;
      RADIX_OCT: scaled = acc_r << 3;
      default:   scaled = (acc_r << 3) + (acc_r << 1);
    endcase
  end

  always_comb begin
    acc_nxt    = acc_r;
    radix_nxt  = radix_r;
    pos_nxt    = pos_r;
    lz_nxt     = lz_r;
    err_nxt    = err_r;
    res.valid  = 1'b0;
    res.value  = (err_r != ST_OK) ? '0 : VALUE_OUT_W'(acc_r);
    res.status = err_r;
    if (take) begin
      if (is_term) begin
        res.valid = 1'b1;
        acc_nxt   = '0;
        radix_nxt = RADIX_DEC;
        pos_nxt   = 2'd0;
        lz_nxt    = 1'b0;
        err_nxt   = ST_OK;
      end else if (err_r == ST_OK) begin
        if (pos_r == 2'd0 && item.code == CH_ZERO) begin
          lz_nxt  = 1'b1;
          pos_nxt = 2'd1;
        end else if (lz_r && pos_r == 2'd1 && item.code == CH_X) begin
          radix_nxt = RADIX_HEX;
          pos_nxt   = 2'd2;
        end else if (lz_r && pos_r == 2'd1 && item.code == CH_O) begin
          radix_nxt = RADIX_OCT;
          pos_nxt   = 2'd2;
        end else if (!dec.ok) begin
          err_nxt = ST_BAD_CHAR;
        end else if (dec.digit >= base) begin
          err_nxt = ST_BIG_DIGIT;
        end else begin
          acc_nxt = scaled + VALUE_WIDTH'(dec.digit);
          if (pos_r != 2'd2) begin
            pos_nxt = pos_r + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      radix_r <= RADIX_DEC;
      pos_r   <= 2'd0;
      lz_r    <= 1'b0;
      err_r   <= ST_OK;
    end else begin
      acc_r   <= acc_nxt;
      radix_r <= radix_nxt;
      pos_r   <= pos_nxt;
      lz_r    <= lz_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/pnp_result_stage.sv
// ============================================================================
// pnp_result_stage
// Output register: holds one result beat until the sink takes it.
// ============================================================================
`default_nettype none

module pnp_result_stage (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire pnp_pkg::result_t                 res,
  output logic                                  out_free,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [pnp_pkg::VALUE_OUT_W-1:0]       out_value,
  output logic [pnp_pkg::STATUS_W-1:0]          out_status
);
  import pnp_pkg::*;

  logic                   valid_r, valid_nxt;
  logic [VALUE_OUT_W-1:0] value_r;
  status_t                status_r;

  assign out_free   = !valid_r || out_ready;
  assign valid_nxt  = res.valid || (valid_r && !out_ready);
  assign out_valid  = valid_r;
  assign out_value  = value_r;
  assign out_status = status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      value_r  <= res.value;
      status_r <= res.status;
    end
  end

endmodule

`default_nettype wire

>>> sim/pnp_checker.sv
// ----------------------------------------------------------------------------
// pnp_checker
// Watches the character and result channels of the prefixed number parser.
// Folds every accepted character into its own copy of the parse state and
// queues the number that each terminator should produce, then compares every
// accepted result beat field by field with the oldest queued number.
// ----------------------------------------------------------------------------
module pnp_checker #(
  parameter int VALUE_WIDTH = pnp_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [pnp_pkg::CHAR_W-1:0]      in_char,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [pnp_pkg::VALUE_OUT_W-1:0] out_value,
  input  logic [pnp_pkg::STATUS_W-1:0]    out_status,
  output int                              mismatches,
  output int                              awaiting
);
  timeunit 1ns;
  timeprecision 1ps;

  import pnp_pkg::*;

  typedef struct {
    logic [VALUE_OUT_W-1:0] value;
    status_t                status;
  } parsed_number_t;

  parsed_number_t         parsed_queue[$];
  logic [VALUE_WIDTH-1:0] acc;
  radix_t                 radix;
  logic [1:0]             taken;
  logic                   zero_lead;
  status_t                held;
  int                     error_total;

  initial begin
    mismatches  = 0;
    awaiting    = 0;
    error_total = 0;
  end

  task automatic clear_parse();
    acc       = '0;
    radix     = RADIX_DEC;
    taken     = 2'd0;
    zero_lead = 1'b0;
    held      = ST_OK;
  endtask

  task automatic take_char(input logic [CHAR_W-1:0] c);
    logic [DIGIT_W-1:0] dval;
    logic [DIGIT_W-1:0] base;
    logic               is_digit;
    parsed_number_t     num;
    if (c == CH_NUL) begin
      num.value  = (held != ST_OK) ? '0 : VALUE_OUT_W'(acc);
      num.status = held;
      parsed_queue.push_back(num);
      clear_parse();
    end else if (held == ST_OK) begin
      if (taken == 2'd0 && c == CH_ZERO) begin
        zero_lead = 1'b1;
        taken     = 2'd1;
      end else if (zero_lead && taken == 2'd1 && (c == CH_X || c == CH_O)) begin
        radix = (c == CH_X) ? RADIX_HEX : RADIX_OCT;
        taken = 2'd2;
      end else begin
        is_digit = 1'b1;
        dval     = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
          dval = DIGIT_W'(c - CH_ZERO);
        end else if (c >= CH_LA && c <= CH_LZ) begin
          dval = DIGIT_W'(c - CH_LA) + DIGIT_W'(10);
        end else if (c >= CH_UA && c <= CH_UZ) begin
          dval = DIGIT_W'(c - CH_UA) + DIGIT_W'(10);
        end else begin
          is_digit = 1'b0;
        end
        case (radix)
          RADIX_HEX: base = DIGIT_W'(16);
          RADIX_OCT: base = DIGIT_W'(8);
          default:   base = DIGIT_W'(10);
        endcase
        if (!is_digit) begin
          held = ST_BAD_CHAR;
        end else if (dval >= base) begin
          held = ST_BIG_DIGIT;
        end else begin
          acc = acc * base + dval;
          if (taken < 2'd2) begin
            taken = taken + 2'd1;
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin
    parsed_number_t want;
    if (!rst_n) begin
      clear_parse();
      parsed_queue.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (parsed_queue.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual value=%h status=%0d",
                   $time, out_value, out_status);
          error_total++;
        end else begin
          want = parsed_queue.pop_front();
          if (out_value !== want.value) begin
            $display("%0t: value mismatch, expected %h, actual %h",
                     $time, want.value, out_value);
            error_total++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, out_status);
            error_total++;
          end
        end
      end
      if (in_valid && in_ready) begin
        take_char(in_char);
      end
    end
    mismatches <= error_total;
    awaiting   <= parsed_queue.size();
  end

endmodule

>>> sim/prefixed_number_parser_top_tb.sv
// ----------------------------------------------------------------------------
// prefixed_number_parser_top_tb
// Drives character beats into the prefixed number parser: a directed set of
// prefix, empty, error and boundary strings, then random numbers in all three
// bases with some corrupted and noise strings. The result side stalls at
// random and once for a long stretch; a checker instance does the comparison.
// ----------------------------------------------------------------------------
module prefixed_number_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pnp_pkg::*;

  localparam int VALUE_WIDTH    = VALUE_WIDTH_DEF;
  localparam int IDLE_PCT       = 28;
  localparam int ITEMS_TOTAL    = 1725;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT    = 3000;
  localparam int SETTLE_CYCLES  = 10;

  typedef enum int {PFX_NONE, PFX_HEX, PFX_OCT, PFX_ZERO} prefix_kind_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              calm;
  int                hold_requests;
  int                chars_sent;
  int                quiet_cycles;
  int                mismatches;
  int                awaiting;
  logic [CHAR_W-1:0] text_q[$];

  pnp_char_if   in_chan ();
  pnp_result_if out_chan ();

  prefixed_number_parser_top #(.VALUE_WIDTH(VALUE_WIDTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  pnp_checker #(.VALUE_WIDTH(VALUE_WIDTH)) checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .in_char    (in_chan.char_code),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_value  (out_chan.value),
    .out_status (out_chan.status),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : result_sink
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = RX_HOLD_CYCLES;
      end
      if (!rst_n) begin
        out_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  task automatic send_char(input logic [CHAR_W-1:0] c);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.char_code <= c;
    do @(posedge clk); while (!in_chan.ready);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i]);
    end
    send_char(CH_NUL);
  endtask

  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
  endtask

  function automatic logic [CHAR_W-1:0] digit_char(input int unsigned v);
    if (v < 10) begin
      return CH_ZERO + CHAR_W'(v);
    end
    if ($urandom_range(0, 1) == 0) begin
      return CH_LA + CHAR_W'(v - 10);
    end
    return CH_UA + CHAR_W'(v - 10);
  endfunction

  task automatic build_text();
    prefix_kind_t pfx;
    int unsigned  base;
    int unsigned  len;
    int unsigned  pick;
    text_q.delete();
    pfx  = prefix_kind_t'($urandom_range(0, 3));
    base = 10;
    case (pfx)
      PFX_HEX: begin
        text_q.push_back(CH_ZERO);
        text_q.push_back(CH_X);
        base = 16;
      end
      PFX_OCT: begin
        text_q.push_back(CH_ZERO);
        text_q.push_back(CH_O);
        base = 8;
      end
      PFX_ZERO: text_q.push_back(CH_ZERO);
      default:  base = 10;
    endcase
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
    repeat (len) text_q.push_back(digit_char($urandom_range(0, base - 1)));
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      text_q.insert($urandom_range(0, text_q.size()), CHAR_W'($urandom_range(1, 255)));
    end else if (pick < 20 && text_q.size() > 0) begin
      text_q[$urandom_range(0, text_q.size() - 1)] = digit_char($urandom_range(base, 35));
    end else if (pick < 26) begin
      text_q.delete();
      repeat ($urandom_range(1, 6)) text_q.push_back(CHAR_W'($urandom_range(1, 255)));
    end
  endtask

  initial begin : char_source
    bit paused;
    bit held_off;
    paused            = 1'b0;
    held_off          = 1'b0;
    chars_sent        = 0;
    quiet_cycles      = 0;
    rst_n             <= 1'b0;
    calm              <= 1'b0;
    hold_requests     <= 0;
    in_chan.valid     <= 1'b0;
    in_chan.char_code <= CH_NUL;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_text("");
    send_text("0x");
    send_text("0o");
    send_char("9");
    send_char(8'hFF);
    send_char("5");
    send_char(CH_NUL);
    send_text("0xAfx");
    send_char("0");
    send_char("o");
    send_char("7");
    send_char(8'h80);
    send_char(CH_NUL);
    send_text("z");
    wait_drained();

    while (chars_sent < ITEMS_TOTAL) begin
      if (!paused && chars_sent >= 600) begin
        paused = 1'b1;
        wait_drained();
      end
      if (!held_off && chars_sent >= 900) begin
        held_off = 1'b1;
        hold_requests <= hold_requests + 1;
      end
      calm <= (chars_sent >= 900 && chars_sent < 1300);
      build_text();
      foreach (text_q[i]) send_char(text_q[i]);
      send_char(CH_NUL);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> prefixed_number_parser_top.f
design/pnp_pkg.sv
design/pnp_if.sv
design/pnp_char_stage.sv
design/pnp_digit_core.sv
design/pnp_result_stage.sv
design/prefixed_number_parser_top.sv
sim/pnp_checker.sv
sim/prefixed_number_parser_top_tb.sv
